// ===== rtl/thrb_pkg.sv =====
// ---------------------------------------------------------------------------
// thrb_pkg: shared types and constants
// Field widths, register codes, request codes and the controller/datapath
// command and status bundles for the timestamp horizon ring buffer.
// ---------------------------------------------------------------------------
package thrb_pkg;

   localparam int STAMP_W    = 32;
   localparam int PAYLOAD_W  = 64;
   localparam int COUNT_W    = 6;
   localparam int WINDOW_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW   = 1'd1;

   // request codes
   localparam logic REQ_PUSH   = 1'b0;
   localparam logic REQ_RECALL = 1'b1;

   localparam int                    CAP_RESET    = 32;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET = 16'd100;

   typedef struct packed {
      logic push;       // write the accepted record at the head
      logic start;      // latch the sample time, clear the best match
      logic scan_next;  // read address runs one entry ahead of oldest
      logic retire;     // drop the oldest record, capture it if in window
      logic load_rsp;   // move the scan result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;      // no records held
      logic last;       // exactly one record held
      logic stop;       // record under test is younger than the sample time
      logic rsp_free;   // output register can take a result this cycle
   } dp_status_type;

endpackage

// ===== rtl/thrb_if.sv =====
// ---------------------------------------------------------------------------
// thrb channel interfaces
// Valid/ready channels for requests and responses of the ring buffer.
// ---------------------------------------------------------------------------
interface thrb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [thrb_pkg::STAMP_W-1:0]        stamp_ms;
   logic [thrb_pkg::PAYLOAD_W-1:0]      payload;

   modport source (output valid, req_type, stamp_ms, payload, input ready);
   modport sink   (input valid, req_type, stamp_ms, payload, output ready);
endinterface

interface thrb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic [thrb_pkg::STAMP_W-1:0]        found_stamp_ms;
   logic [thrb_pkg::PAYLOAD_W-1:0]      found_payload;
   logic [thrb_pkg::COUNT_W-1:0]        entries_left;

   modport source (output valid, found, found_stamp_ms, found_payload, entries_left,
                   input ready);
   modport sink   (input valid, found, found_stamp_ms, found_payload, entries_left,
                   output ready);
endinterface

// ===== rtl/timestamp_horizon_ring_buffer.sv =====
// ---------------------------------------------------------------------------
// timestamp_horizon_ring_buffer: timestamped record ring with windowed recall
// Usage: requests arrive as beats on req_chan. A push beat (req_type 0) stores
// stamp_ms and payload at the head, replacing the oldest record when the ring
// is full; it produces no response. A recall beat (req_type 1) carries a
// sample time, drops every record not younger than it, and returns on rsp_chan
// the newest dropped record whose age is under the window setting, plus the
// number of records left.
// Sequence: a push is written in the cycle it is accepted. A recall goes
// through fetch, one check per record examined (at most the capacity in use)
// and done; the scan reads the record RAM once per cycle, one entry ahead.
// The next request is taken once the result sits in the output register.
// Stall: if rsp_chan is not ready, the result holds in the output register and
// a further recall waits at its end until that beat is taken; pushes go on.
// Reset (synchronous): empties the ring, capacity 32 (or DEPTH if smaller),
// window 100 ms. Writing capacity through csr_ also empties the ring.
// ---------------------------------------------------------------------------
module timestamp_horizon_ring_buffer #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   thrb_req_if.sink                          req_chan,
   thrb_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [thrb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [thrb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   thrb_pkg::ctrl_cmd_type  cmd;
   thrb_pkg::dp_status_type status;

   // sequencer: owns the request handshake and the scan loop
   thrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: record RAM, pointers, settings and the response register
   thrb_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_stamp_ms       (req_chan.stamp_ms),
      .req_payload        (req_chan.payload),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_found          (rsp_chan.found),
      .rsp_found_stamp_ms (rsp_chan.found_stamp_ms),
      .rsp_found_payload  (rsp_chan.found_payload),
      .rsp_entries_left   (rsp_chan.entries_left)
   );

endmodule

// ===== rtl/thrb_ram.sv =====
// ---------------------------------------------------------------------------
// thrb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module thrb_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/thrb_ctrl.sv =====
// ---------------------------------------------------------------------------
// thrb_ctrl: request sequencer
// Takes requests, runs the recall scan one record a cycle, hands off results.
// ---------------------------------------------------------------------------
module thrb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_type,
   output logic                     req_ready,
   input  thrb_pkg::dp_status_type  status,
   output thrb_pkg::ctrl_cmd_type   cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == thrb_pkg::REQ_RECALL) begin
                  cmd.start = 1'b1;
                  state_in  = S_FETCH;
               end else begin
                  cmd.push = 1'b1;
               end
            end
         end
         S_FETCH: begin
            state_in = status.empty ? S_DONE : S_CHECK;
         end
         S_CHECK: begin
            cmd.scan_next = 1'b1;
            if (status.stop) begin
               state_in = S_DONE;
            end else begin
               cmd.retire = 1'b1;
               if (status.last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/thrb_dp.sv =====
// ---------------------------------------------------------------------------
// thrb_dp: ring buffer datapath
// Record RAM, ring pointers, settings, age compare and result register.
// ---------------------------------------------------------------------------
module thrb_dp #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // settings
   input  logic                                 csr_wr_en,
   input  logic [thrb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [thrb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // request fields
   input  logic [thrb_pkg::STAMP_W-1:0]         req_stamp_ms,
   input  logic [thrb_pkg::PAYLOAD_W-1:0]       req_payload,
   // sequencer link
   input  thrb_pkg::ctrl_cmd_type               cmd,
   output thrb_pkg::dp_status_type              status,
   // response
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [thrb_pkg::STAMP_W-1:0]         rsp_found_stamp_ms,
   output logic [thrb_pkg::PAYLOAD_W-1:0]       rsp_found_payload,
   output logic [thrb_pkg::COUNT_W-1:0]         rsp_entries_left
);

   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int REC_W     = thrb_pkg::STAMP_W + DATA_WIDTH;
   localparam int CAP_INIT  = (DEPTH < thrb_pkg::CAP_RESET) ? DEPTH : thrb_pkg::CAP_RESET;
   localparam int COUNT_W   = thrb_pkg::COUNT_W;
   localparam int STAMP_W   = thrb_pkg::STAMP_W;

   // control state
   logic [COUNT_W-1:0]            cap_ff,    cap_in;
   logic [thrb_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [IDX_W-1:0]              oldest_ff, oldest_in;
   logic [COUNT_W-1:0]            count_ff,  count_in;
   logic                          hit_ff,    hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic [STAMP_W-1:0]            sample_ff;
   logic [STAMP_W-1:0]            best_stamp_ff;
   logic [DATA_WIDTH-1:0]         best_payload_ff;
   logic                          found_ff;
   logic [STAMP_W-1:0]            found_stamp_ff;
   logic [DATA_WIDTH-1:0]         found_payload_ff;
   logic [COUNT_W-1:0]            left_ff;

   logic [8:0]                    head_sum;
   logic [IDX_W-1:0]              head_idx;
   logic [8:0]                    inc_sum;
   logic [IDX_W-1:0]              oldest_inc;
   logic [IDX_W-1:0]              rd_addr;
   logic [REC_W-1:0]              rd_data;
   logic [STAMP_W-1:0]            rd_stamp;
   logic [DATA_WIDTH-1:0]         rd_payload;
   logic [STAMP_W-1:0]            age;
   logic                          in_window;
   logic [COUNT_W-1:0]            cap_wr;
   logic                          full;

   // ring arithmetic: both sums stay below twice the capacity
   assign head_sum   = 9'(oldest_ff) + 9'(count_ff);
   assign head_idx   = (head_sum >= 9'(cap_ff)) ? IDX_W'(head_sum - 9'(cap_ff))
                                                : IDX_W'(head_sum);
   assign inc_sum    = 9'(oldest_ff) + 9'd1;
   assign oldest_inc = (inc_sum == 9'(cap_ff)) ? '0 : IDX_W'(inc_sum);
   assign full       = (count_ff == cap_ff);

   // look one entry ahead while scanning so the next record's data is ready for its check
   assign rd_addr = cmd.scan_next ? oldest_inc : oldest_ff;

   thrb_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (head_idx),
      .wr_data ({req_stamp_ms, req_payload[DATA_WIDTH-1:0]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_stamp   = rd_data[REC_W-1 -: STAMP_W];
   assign rd_payload = rd_data[DATA_WIDTH-1:0];
   assign age        = sample_ff - rd_stamp;
   assign in_window  = (age < 32'(window_ff));

   // clamp written capacity into one to DEPTH
   always_comb begin
      cap_wr = csr_wdata[COUNT_W-1:0];
      if (cap_wr == '0) begin
         cap_wr = COUNT_W'(1);
      end else if (9'(cap_wr) > 9'(DEPTH)) begin
         cap_wr = COUNT_W'(DEPTH);
      end
   end

   always_comb begin
      cap_in       = cap_ff;
      window_in    = window_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end

      if (cmd.push) begin
         if (full) begin
            oldest_in = oldest_inc;
         end else begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
      if (cmd.start) begin
         hit_in = 1'b0;
      end
      if (cmd.retire) begin
         count_in  = count_ff - COUNT_W'(1);
         oldest_in = oldest_inc;
         if (in_window) begin
            hit_in = 1'b1;
         end
      end

      if (csr_wr_en) begin
         case (csr_index)
            thrb_pkg::REG_CAPACITY: begin
               cap_in    = cap_wr;
               oldest_in = '0;
               count_in  = '0;
            end
            thrb_pkg::REG_WINDOW: begin
               window_in = csr_wdata[thrb_pkg::WINDOW_W-1:0];
            end
            default: begin
               cap_in = cap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= COUNT_W'(CAP_INIT);
         window_ff    <= thrb_pkg::WINDOW_RESET;
         oldest_ff    <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         window_ff    <= window_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sample_ff       <= req_stamp_ms;
         best_stamp_ff   <= '0;
         best_payload_ff <= '0;
      end else if (cmd.retire && in_window) begin
         best_stamp_ff   <= rd_stamp;
         best_payload_ff <= rd_payload;
      end
      if (cmd.load_rsp) begin
         found_ff         <= hit_ff;
         found_stamp_ff   <= best_stamp_ff;
         found_payload_ff <= best_payload_ff;
         left_ff          <= count_ff;
      end
   end

   assign status.empty    = (count_ff == '0);
   assign status.last     = (count_ff == COUNT_W'(1));
   assign status.stop     = age[STAMP_W-1];
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_stamp_ms = found_stamp_ff;
   assign rsp_found_payload  = thrb_pkg::PAYLOAD_W'(found_payload_ff);
   assign rsp_entries_left   = left_ff;

   a_count_le_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("record count exceeds capacity");

   a_oldest_in_ring: assert property (@(posedge clock) disable iff (reset)
      9'(oldest_ff) < 9'(cap_ff))
      else $error("oldest pointer outside the ring");

   a_retire_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.retire |-> (count_ff != '0))
      else $error("retire on an empty ring");

   a_load_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before handoff");

endmodule
